/* src/edge_aware_2x_pixel_scaler_macros.svh */
`ifndef EDGE_AWARE_2X_PIXEL_SCALER_MACROS_SVH
`define EDGE_AWARE_2X_PIXEL_SCALER_MACROS_SVH

// same-cycle implication on clk, off while rst_n is low
`define EAPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while rst_n is low
`define EAPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/eaps_pkg.sv */
`default_nettype none

package eaps_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 2048;

  localparam int COLOR_W = 24;
  localparam int SIZE_W  = 12;
  localparam int POS_W   = 11;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int WID_W = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic               drain;
  } in_req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] top_left;
    logic [COLOR_W-1:0] top_right;
    logic [COLOR_W-1:0] bottom_left;
    logic [COLOR_W-1:0] bottom_right;
    logic [POS_W-1:0]   block_column;
    logic [POS_W-1:0]   block_row;
    logic               frame_end;
  } out_req_t;

  // one block with its edge-clamped neighborhood
  typedef struct packed {
    logic [COLOR_W-1:0] n;
    logic [COLOR_W-1:0] w;
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] e;
    logic [COLOR_W-1:0] s;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
    logic               frame_end;
  } qent_t;

endpackage

`default_nettype wire

/* src/edge_aware_2x_pixel_scaler.sv */
// Edge-aware 2x pixel scaler: takes 24-bit RGB pixels in raster order and returns one 2x2 block
// of colors per source pixel (EPX/Scale2x corner rule, exact color equality, neighbors past the
// image edge clamp to the center). A pixel's block leaves once the pixel below it arrives, so the
// top row gives no output; after the last row the source sends one image width of drain items to
// flush the final row, and the last block of the frame carries frame_end. Drain items that arrive
// during image rows are dropped. Throughput is one pixel per clock unless output stalls fill the
// queue: the front reads two line banks (each one write and two read ports) once per pixel, and
// the back resolves corners combinationally. out_valid follows the input accept that completes a
// block through the front's s1 registers, the queue and the output register. A four-entry queue
// between front and back absorbs output stalls, and an output register holds a finished block
// while new pixels keep coming in. Registers (byte address 0x0 image_width, 0x4 image_height,
// 12 bits, reset 640x480; 0 acts as 1, oversize acts as 2048) restart the frame when written
// and must only be written while the block is idle. Line store contents are not cleared at
// reset; no clearing pass is needed, since every read whose word feeds a block hits a word
// written earlier in the same frame.
`default_nettype none

module edge_aware_2x_pixel_scaler
  import eaps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // pixel input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_req_t           in_req,
  // block output channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_req_t               out_req,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  logic              reg_wr;
  reg_idx_t          reg_idx;

  // front to queue to back
  logic              q_push;
  qent_t             q_entry;
  logic [QCNT_W-1:0] q_level;
  logic              q_valid;
  qent_t             q_head;
  logic              q_pop;

  // register port: no wait states, word index from address bit 2
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_IMAGE_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = CFG_DW'(width_r);
      REG_IMAGE_HEIGHT: prdata = CFG_DW'(height_r);
      default:          prdata = '0;
    endcase
  end

  // front: frame position, line banks, neighborhood gather
  eaps_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .restart    (reg_wr),
    .cfg_width  (width_r),
    .cfg_height (height_r),
    .in_valid   (in_valid),
    .in_req     (in_req),
    .in_stall   (in_stall),
    .q_level    (q_level),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // short queue so an output stall does not stop the line reads mid-flight
  eaps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .level      (q_level),
    .head_valid (q_valid),
    .head       (q_head)
  );

  // back: corner decisions and the output register
  eaps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

endmodule

`default_nettype wire

/* src/eaps_ram.sv */
`default_nettype none

module eaps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // read-first: a read and a write to one address in a cycle return the old word
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem_r[raddr_a];
      rdata_b <= mem_r[raddr_b];
    end
  end

endmodule

`default_nettype wire

/* src/eaps_front.sv */
`default_nettype none
`include "edge_aware_2x_pixel_scaler_macros.svh"

module eaps_front
  import eaps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              restart,
  input  wire logic [SIZE_W-1:0] cfg_width,
  input  wire logic [SIZE_W-1:0] cfg_height,
  input  wire logic              in_valid,
  input  wire in_req_t           in_req,
  output logic                   in_stall,
  input  wire logic [QCNT_W-1:0] q_level,
  output logic                   q_push,
  output qent_t                  q_entry
);

  logic [WID_W-1:0] wid_eff;
  logic [HGT_W-1:0] hgt_eff;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [HGT_W-1:0] row_r, row_nxt;
  logic             par_r, par_nxt;

  logic             flush;
  logic             accept;
  logic             proceed;
  logic             col_last;
  logic             emit;
  logic [HGT_W-1:0] brow;

  logic [COLOR_W-1:0] rd_a [2];
  logic [COLOR_W-1:0] rd_b [2];

  logic               s1_v_r, s1_v_nxt;
  logic [POS_W-1:0]   s1_col_r;
  logic [POS_W-1:0]   s1_row_r;
  logic               s1_first_r;
  logic               s1_last_r;
  logic               s1_top_r;
  logic               s1_flush_r;
  logic               s1_mid_r;
  logic               s1_fend_r;
  logic [COLOR_W-1:0] s1_pix_r;
  logic [COLOR_W-1:0] last_c_r;

  logic [COLOR_W-1:0] c_word;
  logic [COLOR_W-1:0] n_raw;
  logic [COLOR_W-1:0] e_raw;

  // size clamp: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (cfg_width == '0) begin
      wid_eff = WID_W'(1);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      wid_eff = WID_W'(MAX_WIDTH);
    end else begin
      wid_eff = WID_W'(cfg_width);
    end
    if (cfg_height == '0) begin
      hgt_eff = HGT_W'(1);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      hgt_eff = HGT_W'(MAX_HEIGHT);
    end else begin
      hgt_eff = HGT_W'(cfg_height);
    end
  end

  assign flush    = (row_r >= hgt_eff);
  assign in_stall = ({1'b0, q_level} + {{QCNT_W{1'b0}}, s1_v_r}) >= (QCNT_W + 1)'(QDEPTH);
  assign accept   = in_valid && !in_stall;
  assign proceed  = accept && (flush || !in_req.drain);
  assign col_last = ((WID_W'(col_r) + WID_W'(1)) == wid_eff);
  assign emit     = flush || (row_r != '0);
  assign brow     = flush ? (hgt_eff - HGT_W'(1)) : (row_r - HGT_W'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    par_nxt = par_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      par_nxt = 1'b0;
    end else if (proceed) begin
      if (col_last) begin
        col_nxt = '0;
        if (flush) begin
          row_nxt = '0;
          par_nxt = 1'b0;
        end else begin
          row_nxt = row_r + HGT_W'(1);
          par_nxt = ~par_r;
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  assign s1_v_nxt = proceed && emit && !restart;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      par_r  <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      par_r  <= par_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  // line banks swap roles per row: bank par holds the upper line and takes the new row
  eaps_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk     (clk),
    .we      (proceed && !flush && !par_r),
    .waddr   (col_r),
    .wdata   (in_req.pixel_color),
    .re      (proceed),
    .raddr_a (col_r),
    .raddr_b (col_r + COL_W'(1)),
    .rdata_a (rd_a[0]),
    .rdata_b (rd_b[0])
  );

  eaps_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk     (clk),
    .we      (proceed && !flush && par_r),
    .waddr   (col_r),
    .wdata   (in_req.pixel_color),
    .re      (proceed),
    .raddr_a (col_r),
    .raddr_b (col_r + COL_W'(1)),
    .rdata_a (rd_a[1]),
    .rdata_b (rd_b[1])
  );

  always_ff @(posedge clk) begin
    if (proceed) begin
      s1_col_r   <= POS_W'(col_r);
      s1_row_r   <= POS_W'(brow);
      s1_first_r <= (col_r == '0);
      s1_last_r  <= col_last;
      s1_top_r   <= (brow == '0);
      s1_flush_r <= flush;
      s1_mid_r   <= ~par_r;
      s1_fend_r  <= flush && col_last;
      s1_pix_r   <= in_req.pixel_color;
    end
    if (s1_v_r) begin
      last_c_r <= c_word;
    end
  end

  assign c_word = s1_mid_r ? rd_a[1] : rd_a[0];
  assign e_raw  = s1_mid_r ? rd_b[1] : rd_b[0];
  assign n_raw  = s1_mid_r ? rd_a[0] : rd_a[1];

  // neighbors past the image edge fall back to the center
  assign q_push            = s1_v_r;
  assign q_entry.c         = c_word;
  assign q_entry.n         = s1_top_r   ? c_word : n_raw;
  assign q_entry.w         = s1_first_r ? c_word : last_c_r;
  assign q_entry.e         = s1_last_r  ? c_word : e_raw;
  assign q_entry.s         = s1_flush_r ? c_word : s1_pix_r;
  assign q_entry.col       = s1_col_r;
  assign q_entry.row       = s1_row_r;
  assign q_entry.frame_end = s1_fend_r;

  `EAPS_ASSERT_NOW(a_col_in_range, 1'b1, (WID_W'(col_r) < wid_eff),
                   "column counter ran past the image width")
  `EAPS_ASSERT_NOW(a_row_in_range, 1'b1, (row_r <= hgt_eff),
                   "row counter ran past the flush row")
  `EAPS_ASSERT_NEXT(a_restart_clears, restart, ((col_r == '0) && (row_r == '0) && !s1_v_r),
                    "register write did not restart the frame")

endmodule

`default_nettype wire

/* src/eaps_queue.sv */
`default_nettype none
`include "edge_aware_2x_pixel_scaler_macros.svh"

module eaps_queue
  import eaps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire qent_t             push_entry,
  input  wire logic              pop,
  output logic [QCNT_W-1:0]      level,
  output logic                   head_valid,
  output qent_t                  head
);

  qent_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : (wr_ptr_r + QPTR_W'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : (rd_ptr_r + QPTR_W'(1));
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  assign level      = cnt_r;
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  `EAPS_ASSERT_NOW(a_no_overflow, (push && !pop), (cnt_r != QCNT_W'(QDEPTH)),
                   "block pushed into a full queue")
  `EAPS_ASSERT_NOW(a_ptrs_match_empty, (cnt_r == '0), (wr_ptr_r == rd_ptr_r),
                   "queue pointers disagree with an empty count")

endmodule

`default_nettype wire

/* src/eaps_back.sv */
`default_nettype none

module eaps_back
  import eaps_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_valid,
  input  wire qent_t q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_req_t   out_req
);

  logic     out_valid_r, out_valid_nxt;
  out_req_t out_req_r;
  out_req_t blk;

  logic w_eq_n, n_eq_e, w_eq_s, s_eq_e;

  assign w_eq_n = (q_head.w == q_head.n);
  assign n_eq_e = (q_head.n == q_head.e);
  assign w_eq_s = (q_head.w == q_head.s);
  assign s_eq_e = (q_head.s == q_head.e);

  always_comb begin
    blk.top_left     = (w_eq_n && !n_eq_e && !w_eq_s) ? q_head.w : q_head.c;
    blk.top_right    = (n_eq_e && !w_eq_n && !s_eq_e) ? q_head.e : q_head.c;
    blk.bottom_left  = (w_eq_s && !w_eq_n && !s_eq_e) ? q_head.w : q_head.c;
    blk.bottom_right = (s_eq_e && !w_eq_s && !n_eq_e) ? q_head.e : q_head.c;
    blk.block_column = q_head.col;
    blk.block_row    = q_head.row;
    blk.frame_end    = q_head.frame_end;
  end

  assign q_pop         = q_valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = q_pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_req_r <= blk;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

endmodule

`default_nettype wire

/* bench/edge_aware_2x_pixel_scaler_test.sv */
module edge_aware_2x_pixel_scaler_test;
  import eaps_pkg::*;

  // quiet cycles after the last block before the block counts as idle
  localparam int SETTLE = 16;
  // cycles with no request moving on either channel before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  // most requests a cut-short frame sends
  localparam int CUT_CAP = 400;

  // what a row of the directed table does and how its result is known
  typedef enum logic [1:0] {
    ROW_CFG,      // register write, made only while idle
    ROW_PREDICT,  // pixel, result from the scaler model below
    ROW_QUIET,    // pixel that must give no block
    ROW_SOLID     // pixel whose block is typed in the table
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    reg_idx_t    reg_sel;
    logic [11:0] value;
    in_req_t     px;
    out_req_t    blk;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_req_t           in_req;
  logic              out_valid;
  logic              out_stall;
  out_req_t          out_req;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  edge_aware_2x_pixel_scaler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // scaler model state: two line stores, raster position, previous center
  logic [COLOR_W-1:0] line_above [MAX_WIDTH];
  logic [COLOR_W-1:0] line_here  [MAX_WIDTH];
  int unsigned        col_at;
  int unsigned        row_at;
  logic [COLOR_W-1:0] west_color;
  logic [SIZE_W-1:0]  width_reg;
  logic [SIZE_W-1:0]  height_reg;

  out_req_t    pending_blocks [$];
  int          mismatches;
  int          pixels_sent;
  bit          gaps_on;
  script_row_t script [22];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // register value as the block uses it: zero acts as one, oversize clips
  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] raw,
                                           input int unsigned cap);
    if (raw == 0) return 1;
    if (raw > cap) return cap;
    return raw;
  endfunction

  // advance the scaler by one pixel; returns 1 when a 2x2 block comes out
  function automatic bit predict_block(input in_req_t px, output out_req_t blk);
    int unsigned        wid;
    int unsigned        hgt;
    int unsigned        x;
    int unsigned        r;
    int unsigned        brow;
    bit                 flush;
    bit                 hit;
    logic [COLOR_W-1:0] c;
    logic [COLOR_W-1:0] n;
    logic [COLOR_W-1:0] w;
    logic [COLOR_W-1:0] e;
    logic [COLOR_W-1:0] s;
    wid = eff_size(width_reg, MAX_WIDTH);
    hgt = eff_size(height_reg, MAX_HEIGHT);
    x = col_at;
    r = row_at;
    flush = (r >= hgt);
    hit = 1'b0;
    blk = '0;
    if (x >= wid) x = 0;
    // drain items inside the image rows are dropped with no effect
    if (!flush && px.drain) return 1'b0;
    c = line_here[x];
    if (flush || r > 0) begin
      // the block belongs to the row above the incoming pixel
      brow = flush ? hgt - 1 : r - 1;
      n = (brow == 0) ? c : line_above[x];
      w = (x == 0) ? c : west_color;
      if (x + 1 >= wid) e = c;
      else e = line_here[x + 1];
      s = flush ? c : px.pixel_color;
      blk.top_left     = (w == n && n != e && w != s) ? w : c;
      blk.top_right    = (n == e && n != w && e != s) ? e : c;
      blk.bottom_left  = (w == s && w != n && s != e) ? w : c;
      blk.bottom_right = (s == e && w != s && n != e) ? e : c;
      blk.block_column = POS_W'(x);
      blk.block_row    = POS_W'(brow);
      blk.frame_end    = flush && (x + 1 == wid);
      hit = 1'b1;
    end
    if (!flush) begin
      line_above[x] = c;
      line_here[x]  = px.pixel_color;
    end
    west_color = c;
    x++;
    if (x >= wid) begin
      x = 0;
      r = flush ? 0 : r + 1;
    end
    col_at = x;
    row_at = r;
    return hit;
  endfunction

  function automatic bit same_block(input out_req_t want, input out_req_t got);
    return got.top_left === want.top_left && got.top_right === want.top_right &&
           got.bottom_left === want.bottom_left &&
           got.bottom_right === want.bottom_right &&
           got.block_column === want.block_column &&
           got.block_row === want.block_row && got.frame_end === want.frame_end;
  endfunction

  // helpers that build rows of the directed table
  function automatic script_row_t cfg_row(input reg_idx_t sel, input logic [11:0] v);
    script_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.reg_sel = sel;
    row.value = v;
    return row;
  endfunction

  function automatic script_row_t step_row(input logic [23:0] color, input bit drain,
                                           input row_kind_t kind);
    script_row_t row;
    row = '0;
    row.kind = kind;
    row.px.pixel_color = color;
    row.px.drain = drain;
    return row;
  endfunction

  // block with all four corners the same color
  function automatic script_row_t solid_row(input logic [23:0] color, input bit drain,
                                            input logic [23:0] corner, input int col,
                                            input int brow, input bit last);
    script_row_t row;
    row = step_row(color, drain, ROW_SOLID);
    row.blk.top_left     = corner;
    row.blk.top_right    = corner;
    row.blk.bottom_left  = corner;
    row.blk.bottom_right = corner;
    row.blk.block_column = POS_W'(col);
    row.blk.block_row    = POS_W'(brow);
    row.blk.frame_end    = last;
    return row;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!gaps_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // drive one pixel request, hold it until taken, then log what it should produce
  task automatic push_pixel(input in_req_t px, input row_kind_t kind,
                            input out_req_t typed_blk);
    int       gap;
    bit       hit;
    out_req_t blk;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req = px;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    hit = predict_block(px, blk);
    if (kind == ROW_SOLID) pending_blocks.push_back(typed_blk);
    else if (kind == ROW_PREDICT && hit) pending_blocks.push_back(blk);
  endtask

  // let every outstanding block drain, then give the pipeline time to empty
  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // two-phase register write; a write also restarts the frame
  task automatic cfg_write(input reg_idx_t sel, input logic [SIZE_W-1:0] v);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = CFG_AW'(4 * int'(sel));
    // upper data bits are ignored by the block, so sometimes fill them
    pwdata = {($urandom_range(0, 1) != 0) ? 20'($urandom) : 20'h0, v};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (sel == REG_IMAGE_WIDTH) width_reg = v;
    else height_reg = v;
    col_at = 0;
    row_at = 0;
    west_color = '0;
  endtask

  // set a size, then stream whole frames: image rows from a small palette,
  // a few stray drain requests, and one flush row; optionally stop mid-frame
  task automatic run_phase(input logic [SIZE_W-1:0] wv, input logic [SIZE_W-1:0] hv,
                           input int frames, input bit cut);
    int unsigned        wid;
    int unsigned        hgt;
    int unsigned        total;
    int unsigned        stop;
    int                 npal;
    logic [COLOR_W-1:0] pal [4];
    in_req_t            px;
    wait_idle();
    if ($urandom_range(0, 1) != 0) begin
      cfg_write(REG_IMAGE_WIDTH, wv);
      cfg_write(REG_IMAGE_HEIGHT, hv);
    end else begin
      cfg_write(REG_IMAGE_HEIGHT, hv);
      cfg_write(REG_IMAGE_WIDTH, wv);
    end
    wid = eff_size(wv, MAX_WIDTH);
    hgt = eff_size(hv, MAX_HEIGHT);
    total = wid * (hgt + 1);
    for (int f = 0; f < frames; f++) begin
      // few colors so that neighbors match often enough to bend corners
      npal = $urandom_range(1, 4);
      foreach (pal[k]) begin
        case ($urandom_range(0, 5))
          0: pal[k] = '0;
          1: pal[k] = '1;
          default: pal[k] = COLOR_W'($urandom);
        endcase
      end
      stop = (cut && f == frames - 1) ?
             $urandom_range(1, (total < CUT_CAP) ? total : CUT_CAP) : total;
      for (int unsigned i = 0; i < stop; i++) begin
        if (i < wid * hgt) begin
          if ($urandom_range(0, 19) == 0) begin
            // stray drain inside the image: ignored by the block
            px.pixel_color = COLOR_W'($urandom);
            px.drain = 1'b1;
            push_pixel(px, ROW_PREDICT, '0);
          end
          px.drain = 1'b0;
          if ($urandom_range(0, 7) == 0) px.pixel_color = COLOR_W'($urandom);
          else px.pixel_color = pal[$urandom_range(0, npal - 1)];
        end else begin
          // flush row: drain bit mostly set, color is don't-care
          px.pixel_color = COLOR_W'($urandom);
          px.drain = ($urandom_range(0, 3) != 0);
        end
        push_pixel(px, ROW_PREDICT, '0);
        pixels_sent++;
      end
    end
  endtask

  // result side: random stall bursts, mostly short, with some long calm stretches
  initial begin : result_backpressure
    int calm;
    int shut;
    out_stall = 1'b0;
    forever begin
      calm = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      shut = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
      repeat (calm) @(negedge clk);
      out_stall = 1'b1;
      repeat (shut) @(negedge clk);
      out_stall = 1'b0;
    end
  end

  // every block taken is matched against the oldest expected one
  always @(posedge clk) begin : block_check
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_blocks.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected block col %0d row %0d", out_req.block_column,
                   out_req.block_row);
        mismatches++;
      end else begin
        want = pending_blocks.pop_front();
        if (!same_block(want, out_req)) begin
          if (mismatches < 10)
            $display({"block mismatch: expected %h %h %h %h col %0d row %0d end %b, ",
                      "got %h %h %h %h col %0d row %0d end %b"},
                     want.top_left, want.top_right, want.bottom_left, want.bottom_right,
                     want.block_column, want.block_row, want.frame_end,
                     out_req.top_left, out_req.top_right, out_req.bottom_left,
                     out_req.bottom_right, out_req.block_column, out_req.block_row,
                     out_req.frame_end);
          mismatches++;
        end
      end
    end
  end

  // ends the run when neither channel moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    pixels_sent = 0;
    gaps_on = 1'b1;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    col_at = 0;
    row_at = 0;
    west_color = '0;
    foreach (line_here[k]) begin
      line_here[k] = '0;
      line_above[k] = '0;
    end

    script = '{
      // size zero acts as a 1x1 image: every neighbor clamps to the center
      cfg_row(REG_IMAGE_WIDTH, 12'd0),
      cfg_row(REG_IMAGE_HEIGHT, 12'd0),
      step_row(24'hFFFFFF, 1'b0, ROW_QUIET),
      solid_row(24'h123456, 1'b1, 24'hFFFFFF, 0, 0, 1'b1),
      // stray drain in the top row is dropped
      step_row(24'hABCDEF, 1'b1, ROW_QUIET),
      step_row(24'h000000, 1'b0, ROW_QUIET),
      // flush request with the drain bit low still flushes, color ignored
      solid_row(24'hABCDEF, 1'b0, 24'h000000, 0, 0, 1'b1),
      // 3x3 image: center sees matching west/north and east/south pairs
      cfg_row(REG_IMAGE_WIDTH, 12'd3),
      cfg_row(REG_IMAGE_HEIGHT, 12'd3),
      step_row(24'h00FF00, 1'b0, ROW_QUIET),
      step_row(24'hFFFFFF, 1'b0, ROW_QUIET),
      step_row(24'h800001, 1'b0, ROW_QUIET),
      step_row(24'hFFFFFF, 1'b0, ROW_PREDICT),
      step_row(24'h00FF00, 1'b0, ROW_PREDICT),
      step_row(24'hFFFFFF, 1'b1, ROW_QUIET),
      step_row(24'h0000FF, 1'b0, ROW_PREDICT),
      step_row(24'hFFFFFF, 1'b0, ROW_PREDICT),
      step_row(24'h0000FF, 1'b0, ROW_PREDICT),
      step_row(24'h7F7F7F, 1'b0, ROW_PREDICT),
      // flush row emits the bottom row, last one marks the frame end
      step_row(24'h000000, 1'b1, ROW_PREDICT),
      step_row(24'hFFFFFF, 1'b1, ROW_PREDICT),
      step_row(24'h5A5A5A, 1'b0, ROW_PREDICT)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(script[i].reg_sel, script[i].value);
      end else begin
        push_pixel(script[i].px, script[i].kind, script[i].blk);
      end
    end

    // oversize width and oversize height once each, cut short mid-frame
    gaps_on = 1'b0;
    run_phase(12'hFFF, 12'd1, 1, 1'b1);
    run_phase(12'd1, 12'hFFF, 1, 1'b1);

    // mostly small images at many sizes, some frames cut short by a size write
    while (pixels_sent < 1700) begin
      logic [SIZE_W-1:0] wv;
      logic [SIZE_W-1:0] hv;
      int                roll;
      gaps_on = ($urandom_range(0, 3) != 0);
      roll = $urandom_range(0, 19);
      if (roll == 0) wv = 12'd0;
      else if (roll == 1) wv = 12'd1;
      else if (roll < 15) wv = SIZE_W'($urandom_range(2, 8));
      else wv = SIZE_W'($urandom_range(9, 48));
      roll = $urandom_range(0, 19);
      if (roll == 0) hv = 12'd0;
      else if (roll < 4) hv = 12'd1;
      else if (roll < 17) hv = SIZE_W'($urandom_range(2, 6));
      else hv = SIZE_W'($urandom_range(7, 16));
      run_phase(wv, hv, $urandom_range(1, 3), $urandom_range(0, 5) == 0);
    end

    wait_idle();
    if (mismatches == 0 && pending_blocks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/eaps_pkg.sv
src/eaps_ram.sv
src/eaps_front.sv
src/eaps_queue.sv
src/eaps_back.sv
src/edge_aware_2x_pixel_scaler.sv
bench/edge_aware_2x_pixel_scaler_test.sv
